[src/tpps_pkg.sv]
// Shared constants and types for the timer prescaler/period splitter.
package tpps_pkg;

  // Default width of the timer period counter.
  localparam int COUNT_BITS_DEF = 16;
  // Quotient bits resolved by the cell chain; the quotient never exceeds 16 bits.
  localparam int QuotBits = 16;
  // Divisor width, holds 1..65536.
  localparam int DsrBits = 17;
  localparam int TotalBits = 32;
  localparam logic [DsrBits-1:0] PrescaleMax = 17'h10000;

  // Data handed from one division cell to the next.
  typedef struct packed {
    logic [DsrBits-1:0]  rem;  // partial remainder, always below dsr
    logic [QuotBits-1:0] dvd;  // dividend bits not yet shifted in, MSB first
    logic [DsrBits-1:0]  dsr;  // prescale, the divisor
    logic [QuotBits-1:0] quo;  // quotient bits resolved so far
  } div_t;

endpackage

[src/tpps_in_if.sv]
// Input channel: one total period per beat.
interface tpps_in_if;
  logic                             valid;
  logic                             ready;
  logic [tpps_pkg::TotalBits-1:0]   total_cycles;

  modport source (output valid, output total_cycles, input ready);
  modport sink (input valid, input total_cycles, output ready);
endinterface

[src/tpps_out_if.sv]
// Output channel: prescale, period count and packed register word per beat.
interface tpps_out_if;
  logic                             valid;
  logic                             ready;
  logic [tpps_pkg::DsrBits-1:0]     prescale;
  logic [tpps_pkg::QuotBits-1:0]    period_count;
  logic [tpps_pkg::TotalBits-1:0]   packed_word;

  modport source (output valid, output prescale, output period_count, output packed_word,
                  input ready);
  modport sink (input valid, input prescale, input period_count, input packed_word,
                output ready);
endinterface

[src/tpps_prep.sv]
// Entry stage: derives the prescale and seeds the division chain.
module tpps_prep #(
  parameter int COUNT_BITS = tpps_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           valid_up,
  input  logic [tpps_pkg::TotalBits-1:0] total,
  output logic                           ready_up,
  output logic                           valid,
  output tpps_pkg::div_t                 data,
  input  logic                           ready_dn
);

  logic [tpps_pkg::TotalBits-1:0] shifted;
  logic [tpps_pkg::DsrBits-1:0]   pre;
  tpps_pkg::div_t                 data_next;

  assign ready_up = !valid || ready_dn;

  // prescale = min((total >> COUNT_BITS) + 1, 65536)
  always_comb begin
    shifted = total >> COUNT_BITS;
    if (shifted[tpps_pkg::TotalBits-1:tpps_pkg::QuotBits] != '0) begin
      pre = tpps_pkg::PrescaleMax;
    end else begin
      pre = {1'b0, shifted[tpps_pkg::QuotBits-1:0]} + tpps_pkg::DsrBits'(1);
    end
    data_next.rem = {1'b0, total[tpps_pkg::TotalBits-1:tpps_pkg::QuotBits]};
    data_next.dvd = total[tpps_pkg::QuotBits-1:0];
    data_next.dsr = pre;
    data_next.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      data <= data_next;
    end
  end

endmodule

[src/tpps_div_cell.sv]
// One restoring-division cell: resolves one quotient bit per beat.
module tpps_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_up,
  input  tpps_pkg::div_t data_up,
  output logic           ready_up,
  output logic           valid,
  output tpps_pkg::div_t data,
  input  logic           ready_dn
);

  logic [tpps_pkg::DsrBits:0] trial;
  logic                       qbit;
  tpps_pkg::div_t             data_next;

  assign ready_up = !valid || ready_dn;

  always_comb begin
    trial = {data_up.rem, data_up.dvd[tpps_pkg::QuotBits-1]};
    qbit  = trial >= {1'b0, data_up.dsr};
    data_next.dsr = data_up.dsr;
    data_next.dvd = {data_up.dvd[tpps_pkg::QuotBits-2:0], 1'b0};
    data_next.quo = {data_up.quo[tpps_pkg::QuotBits-2:0], qbit};
    if (qbit) begin
      data_next.rem = tpps_pkg::DsrBits'(trial - {1'b0, data_up.dsr});
    end else begin
      data_next.rem = trial[tpps_pkg::DsrBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      data <= data_next;
    end
  end

endmodule

[src/timer_prescaler_period_split.sv]
// Top level of the timer prescaler/period splitter.
//
// Splits a 32-bit timer period (in input-clock cycles) into a prescale
// (1..65536, the smallest divider whose quotient fits in COUNT_BITS bits,
// capped at 65536) and a period count (total / prescale, low COUNT_BITS bits),
// plus the packed register word (prescale << 16) + count, modulo 2^32, so a
// prescale of 65536 drops out of the word. One result beat per input beat,
// in order. Throughput is one beat per clock while the output is not stalled.
// An accepted beat lands in the entry stage on the accepting edge, then
// moves through a chain of 16 division cells, each resolving one quotient
// bit, and into the output register. Every stage has its own valid bit
// and stalls only when it is full and the stage after it cannot take a
// beat, so the input keeps taking beats while a result waits as long as
// there is a bubble anywhere in the chain.
module timer_prescaler_period_split #(
  parameter int COUNT_BITS = tpps_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tpps_in_if.sink       period,
  tpps_out_if.source    split
);

  localparam int NCells = tpps_pkg::QuotBits;
  // Keep only the low COUNT_BITS bits of the quotient.
  localparam logic [tpps_pkg::QuotBits-1:0] CountMask =
    tpps_pkg::QuotBits'((64'd1 << COUNT_BITS) - 64'd1);

  // Stage 0 is the entry stage, stages 1..NCells the division cells.
  tpps_pkg::div_t stage_data  [0:NCells];
  logic           stage_valid [0:NCells];
  logic           stage_ready [0:NCells];

  logic                            out_valid;
  logic                            out_ready_up;
  logic [tpps_pkg::DsrBits-1:0]    out_prescale;
  logic [tpps_pkg::QuotBits-1:0]   out_count;
  logic [tpps_pkg::TotalBits-1:0]  out_word;
  logic [tpps_pkg::QuotBits-1:0]   count_next;

  // Entry: prescale and the seed remainder.
  tpps_prep #(
    .COUNT_BITS (COUNT_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .valid_up (period.valid),
    .total    (period.total_cycles),
    .ready_up (period.ready),
    .valid    (stage_valid[0]),
    .data     (stage_data[0]),
    .ready_dn (stage_ready[0])
  );

  // Division chain, quotient MSB first.
  for (genvar i = 1; i <= NCells; i++) begin : g_cell
    tpps_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_up (stage_valid[i-1]),
      .data_up  (stage_data[i-1]),
      .ready_up (stage_ready[i-1]),
      .valid    (stage_valid[i]),
      .data     (stage_data[i]),
      .ready_dn (stage_ready[i])
    );
  end

  // Output register.
  assign out_ready_up        = !out_valid || split.ready;
  assign stage_ready[NCells] = out_ready_up;
  assign count_next          = stage_data[NCells].quo & CountMask;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready_up) begin
      out_valid <= stage_valid[NCells];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready_up && stage_valid[NCells]) begin
      out_prescale <= stage_data[NCells].dsr;
      out_count    <= count_next;
      // Count is below 2^16, so the add is a plain concatenation.
      out_word     <= {stage_data[NCells].dsr[tpps_pkg::QuotBits-1:0], count_next};
    end
  end

  assign split.valid        = out_valid;
  assign split.prescale     = out_prescale;
  assign split.period_count = out_count;
  assign split.packed_word  = out_word;

  // Prescale is never zero and never above 65536.
  a_prescale_range: assert property (@(posedge clk) disable iff (rst)
    split.valid |-> (split.prescale != '0 && split.prescale <= tpps_pkg::PrescaleMax))
    else $error("prescale out of range");

  // Packed word carries the low prescale bits and the count.
  a_word_fields: assert property (@(posedge clk) disable iff (rst)
    split.valid |-> (split.packed_word[tpps_pkg::QuotBits-1:0] == split.period_count &&
                     split.packed_word[tpps_pkg::TotalBits-1:tpps_pkg::QuotBits] ==
                     split.prescale[tpps_pkg::QuotBits-1:0]))
    else $error("packed word does not match fields");

  // Remainder leaving the chain stays below the divisor.
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    stage_valid[NCells] |-> stage_data[NCells].rem < stage_data[NCells].dsr)
    else $error("division remainder not below prescale");

  // An accepted beat lands in the entry stage.
  a_entry_fill: assert property (@(posedge clk) disable iff (rst)
    (period.valid && period.ready) |=> stage_valid[0])
    else $error("accepted beat lost at entry");

endmodule
